// ===== hw/rtl/epms_pkg.sv =====
// Shared types and constants for the energy page migration selector.
package epms_pkg;

  localparam int unsigned ENERGY_W = 32;
  localparam int unsigned NODE_W   = 3;
  localparam int unsigned PID_W    = 22;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned PAGES_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic signed [ENERGY_W-1:0] MAX_THRESHOLD_RST  = 32'sd65536;  // 1.0
  localparam logic        [ENERGY_W-1:0] DIFF_THRESHOLD_RST = 32'd49152;   // 0.75
  localparam logic        [PAGES_W-1:0]  MAX_PAGES_RST      = 6'd15;
  localparam logic        [ACC_W-1:0]    LOCALITY_LIMIT_RST = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_THRESHOLD  = 2'd0,
    CFG_DIFF_THRESHOLD = 2'd1,
    CFG_MAX_PAGES      = 2'd2,
    CFG_LOCALITY_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_ENERGY = 1'b0,
    REQ_PAGE   = 1'b1
  } req_type_t;

  typedef enum logic {
    KIND_DECISION = 1'b0,
    KIND_PAGE     = 1'b1
  } result_kind_t;

endpackage

// ===== hw/rtl/energy_page_migration_selector_top.sv =====
// Energy page migration selector: round decision and page migration orders.

// Takes one request per cycle unless a stalled output raises in_stall: a request
// is captured in an input register, checked against the running round state in
// one pass of compare logic, and its result (if any) lands in an output register.
// Energy samples track the hottest and coolest node of a round (earlier node wins
// ties); the sample flagged last_node closes the round and always yields a
// decision. Page candidates then yield migration orders from the hottest to the
// coolest node while migration is on, up to max_pages per round. Configuration
// writes are always ready and should be issued while idle.
module energy_page_migration_selector_top #(
  parameter int unsigned NODES = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic signed [epms_pkg::ENERGY_W-1:0]   node_energy,
  input  logic                                   last_node,
  input  logic        [epms_pkg::PID_W-1:0]      pid,
  input  logic        [epms_pkg::ADDR_W-1:0]     page_addr,
  input  logic        [epms_pkg::NODE_W-1:0]     page_node,
  input  logic        [epms_pkg::ACC_W-1:0]      node_accesses,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   result_kind,
  output logic                                   migrate_on,
  output logic        [epms_pkg::NODE_W-1:0]     source_node,
  output logic        [epms_pkg::NODE_W-1:0]     dest_node,
  output logic        [epms_pkg::PID_W-1:0]      out_pid,
  output logic        [epms_pkg::ADDR_W-1:0]     out_addr,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [epms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [epms_pkg::ENERGY_W-1:0]   cfg_data
);

  localparam int unsigned SEEN_W = $clog2(NODES + 1);
  localparam logic [SEEN_W-1:0] NODES_CNT = SEEN_W'(NODES);

  // configuration registers
  logic signed [epms_pkg::ENERGY_W-1:0] max_threshold;
  logic        [epms_pkg::ENERGY_W-1:0] diff_threshold;
  logic        [epms_pkg::PAGES_W-1:0]  max_pages;
  logic        [epms_pkg::ACC_W-1:0]    locality_limit;

  // round state
  logic signed [epms_pkg::ENERGY_W-1:0] peak_value, peak_value_next;
  logic signed [epms_pkg::ENERGY_W-1:0] low_value, low_value_next;
  logic        [epms_pkg::NODE_W-1:0]   peak_node, peak_node_next;
  logic        [epms_pkg::NODE_W-1:0]   low_node, low_node_next;
  logic        [SEEN_W-1:0]             nodes_seen, nodes_seen_next;
  logic                                 enabled, enabled_next;
  logic        [epms_pkg::PAGES_W-1:0]  pages_chosen, pages_chosen_next;
  logic                                 loading, loading_next;

  // input register
  logic                                 s1_valid;
  logic                                 s1_type;
  logic signed [epms_pkg::ENERGY_W-1:0] s1_energy;
  logic                                 s1_last;
  logic        [epms_pkg::PID_W-1:0]    s1_pid;
  logic        [epms_pkg::ADDR_W-1:0]   s1_addr;
  logic        [epms_pkg::NODE_W-1:0]   s1_node;
  logic        [epms_pkg::ACC_W-1:0]    s1_acc;

  logic out_adv;
  logic s1_adv;
  logic produce;
  logic        [epms_pkg::ENERGY_W-1:0] spread;
  logic                                 decide_on;

  assign cfg_ready = 1'b1;
  assign out_adv   = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_adv;
  assign in_stall  = s1_valid && !out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_threshold  <= epms_pkg::MAX_THRESHOLD_RST;
      diff_threshold <= epms_pkg::DIFF_THRESHOLD_RST;
      max_pages      <= epms_pkg::MAX_PAGES_RST;
      locality_limit <= epms_pkg::LOCALITY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (epms_pkg::cfg_idx_t'(cfg_index))
        epms_pkg::CFG_MAX_THRESHOLD:  max_threshold  <= $signed(cfg_data);
        epms_pkg::CFG_DIFF_THRESHOLD: diff_threshold <= cfg_data;
        epms_pkg::CFG_MAX_PAGES:      max_pages      <= cfg_data[epms_pkg::PAGES_W-1:0];
        epms_pkg::CFG_LOCALITY_LIMIT: locality_limit <= cfg_data[epms_pkg::ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_type   <= req_type;
      s1_energy <= node_energy;
      s1_last   <= last_node;
      s1_pid    <= pid;
      s1_addr   <= page_addr;
      s1_node   <= page_node;
      s1_acc    <= node_accesses;
    end
  end

  always_comb begin
    peak_value_next   = peak_value;
    low_value_next    = low_value;
    peak_node_next    = peak_node;
    low_node_next     = low_node;
    nodes_seen_next   = nodes_seen;
    enabled_next      = enabled;
    pages_chosen_next = pages_chosen;
    loading_next      = loading;
    produce           = 1'b0;
    spread            = '0;
    decide_on         = 1'b0;

    if (s1_type == epms_pkg::REQ_ENERGY) begin
      if (!loading) begin
        // first sample opens a new round as node 0
        loading_next      = 1'b1;
        enabled_next      = 1'b0;
        pages_chosen_next = '0;
        peak_value_next   = s1_energy;
        low_value_next    = s1_energy;
        peak_node_next    = '0;
        low_node_next     = '0;
        nodes_seen_next   = SEEN_W'(1);
      end else if (nodes_seen < NODES_CNT) begin
        if (s1_energy > peak_value) begin
          peak_value_next = s1_energy;
          peak_node_next  = epms_pkg::NODE_W'(nodes_seen);
        end
        if (s1_energy < low_value) begin
          low_value_next = s1_energy;
          low_node_next  = epms_pkg::NODE_W'(nodes_seen);
        end
        nodes_seen_next = nodes_seen + SEEN_W'(1);
      end

      // peak never drops below low, so the spread fits in 32 unsigned bits
      spread    = peak_value_next - low_value_next;
      decide_on = (peak_value_next >= max_threshold)
               && (spread >= diff_threshold);
      if (s1_last) begin
        enabled_next = decide_on;
        loading_next = 1'b0;
        produce      = 1'b1;
      end
    end else begin
      if (!loading && enabled && (pages_chosen < max_pages)
          && (s1_node == peak_node) && (s1_acc <= locality_limit)) begin
        pages_chosen_next = pages_chosen + epms_pkg::PAGES_W'(1);
        produce           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value   <= '0;
      low_value    <= '0;
      peak_node    <= '0;
      low_node     <= '0;
      nodes_seen   <= '0;
      enabled      <= 1'b0;
      pages_chosen <= '0;
      loading      <= 1'b0;
    end else if (s1_adv) begin
      peak_value   <= peak_value_next;
      low_value    <= low_value_next;
      peak_node    <= peak_node_next;
      low_node     <= low_node_next;
      nodes_seen   <= nodes_seen_next;
      enabled      <= enabled_next;
      pages_chosen <= pages_chosen_next;
      loading      <= loading_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && produce) begin
      source_node <= peak_node_next;
      dest_node   <= low_node_next;
      if (s1_type == epms_pkg::REQ_ENERGY) begin
        result_kind <= epms_pkg::KIND_DECISION;
        migrate_on  <= enabled_next;
        out_pid     <= '0;
        out_addr    <= '0;
      end else begin
        result_kind <= epms_pkg::KIND_PAGE;
        migrate_on  <= 1'b1;
        out_pid     <= s1_pid;
        out_addr    <= s1_addr;
      end
    end
  end

  a_page_means_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == epms_pkg::KIND_PAGE) |-> migrate_on)
    else $error("page order without migration enabled");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_seen <= NODES_CNT)
    else $error("node sample count past node total");

  a_open_round_count: assert property (@(posedge clk) disable iff (rst)
    loading |-> (nodes_seen != '0))
    else $error("open round with no samples");

  a_round_start: assert property (@(posedge clk) disable iff (rst)
    $rose(loading) |-> (!enabled && (pages_chosen == '0)))
    else $error("new round did not clear migration state");

  a_page_only_when_enabled: assert property (@(posedge clk) disable iff (rst)
    s1_adv && produce && (s1_type == epms_pkg::REQ_PAGE) |-> (enabled && !loading))
    else $error("page order outside an enabled round");

endmodule
